FILE: sv/nfa_word_acceptor_core_assert.svh
// assertion macros shared by the rtl
`ifndef NFA_WORD_ACCEPTOR_CORE_ASSERT_SVH
`define NFA_WORD_ACCEPTOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define NWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nwa check failed");

// next-cycle implication, disabled while in reset
`define NWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nwa check failed");

`endif

FILE: sv/nwa_pkg.sv
`timescale 1ns / 1ps
package nwa_pkg;

	localparam int NUM_STATES    = 32;
	localparam int ALPHABET_SIZE = 256;
	localparam int STORE_DEPTH   = NUM_STATES * ALPHABET_SIZE;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int STATE_W       = $clog2(NUM_STATES);
	localparam int ORIGIN_W      = 5;
	localparam int SYM_W         = 8;
	localparam int MASK_W        = 32;

	typedef logic [NUM_STATES-1:0] state_set_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [STATE_W-1:0]    state_idx_t;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_BEGIN  = 2'd1,
		REQ_SYMBOL = 2'd2
	} req_t;

	typedef enum logic [0:0] {
		CFG_INITIAL_MASK = 1'b0,
		CFG_FINAL_MASK   = 1'b1
	} cfg_idx_t;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_ADD_RD = 7'b0000100,
		ST_ADD_WR = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_DRAIN  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} fsm_t;

	// row per origin state, column per symbol
	function automatic addr_t store_addr(input logic [ORIGIN_W-1:0] origin,
			input logic [SYM_W-1:0] sym);
		return addr_t'(origin) * addr_t'(ALPHABET_SIZE) + addr_t'(sym);
	endfunction

endpackage

FILE: sv/nwa_ram.sv
`timescale 1ns / 1ps
module nwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/nfa_word_acceptor_core.sv
`timescale 1ns / 1ps
// symbol item: 32 successor-memory reads, then the drain and finish states, one read port
//   result once the result register is free; in_stall stays high until then, one item at a time
// add item: read-modify-write of one entry in the ADD_RD and ADD_WR states;
//   begin and unused items go straight to the finish state
// after reset the successor memory is cleared one entry a cycle, all 8192 entries,
//   with in_stall high; configuration writes are taken during that time
`include "nfa_word_acceptor_core_assert.svh"
module nfa_word_acceptor_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  nwa_pkg::cfg_idx_t     cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [4:0]            origin_state,
	input  logic [7:0]            symbol,
	input  logic [4:0]            target_state,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           active_states,
	output logic                  accepted
);
	import nwa_pkg::*;

	fsm_t                  state_q;
	addr_t                 clr_q;
	state_idx_t            scan_idx_q;
	logic [ORIGIN_W-1:0]   origin_q;
	logic [SYM_W-1:0]      sym_q;
	logic [ORIGIN_W-1:0]   target_q;
	logic [MASK_W-1:0]     initial_q;
	logic [MASK_W-1:0]     final_q;
	state_set_t            cur_q;
	state_set_t            acc_q;
	logic                  hit_s1;
	logic                  out_valid_q;
	logic [MASK_W-1:0]     active_q;
	logic                  accepted_q;

	logic                  ram_we;
	addr_t                 ram_waddr;
	state_set_t            ram_wdata;
	logic                  ram_re;
	addr_t                 ram_raddr;
	state_set_t            ram_rdata;
	logic                  accept;
	logic                  out_free;
	logic                  add_ok;
	logic                  sym_ok;
	state_set_t            final_set;
	logic                  scan_last;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign add_ok    = (int'(origin_state) < NUM_STATES) && (int'(target_state) < NUM_STATES)
		&& (int'(symbol) < ALPHABET_SIZE);
	assign sym_ok    = (int'(symbol) < ALPHABET_SIZE);
	assign final_set = final_q[NUM_STATES-1:0];
	assign scan_last = (state_q == ST_SCAN) && (scan_idx_q == state_idx_t'(NUM_STATES - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_ADD_WR) begin
			ram_we    = 1'b1;
			ram_waddr = store_addr(origin_q, sym_q);
			ram_wdata = ram_rdata | (state_set_t'(1) << target_q);
		end
	end

	assign ram_re    = (state_q == ST_SCAN) || (state_q == ST_ADD_RD);
	assign ram_raddr = (state_q == ST_SCAN) ? store_addr(ORIGIN_W'(scan_idx_q), sym_q)
		: store_addr(origin_q, sym_q);

	nwa_ram #(
		.WIDTH(NUM_STATES),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= '0;
			final_q   <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_INITIAL_MASK: initial_q <= cfg_data;
				CFG_FINAL_MASK:   final_q   <= cfg_data;
			endcase
		end
	end

	// payload of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			origin_q <= origin_state;
			sym_q    <= symbol;
			target_q <= target_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_idx_q  <= '0;
			cur_q       <= '0;
			acc_q       <= '0;
			hit_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			active_q    <= '0;
			accepted_q  <= 1'b0;
		end else begin
			hit_s1 <= (state_q == ST_SCAN) && cur_q[scan_idx_q];
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_ADD: begin
								state_q <= add_ok ? ST_ADD_RD : ST_FINISH;
							end
							REQ_BEGIN: begin
								cur_q   <= initial_q[NUM_STATES-1:0];
								state_q <= ST_FINISH;
							end
							REQ_SYMBOL: begin
								if (sym_ok) begin
									scan_idx_q <= '0;
									acc_q      <= '0;
									state_q    <= ST_SCAN;
								end else begin
									cur_q   <= '0;
									state_q <= ST_FINISH;
								end
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_WR;
				end
				ST_ADD_WR: begin
					state_q <= ST_FINISH;
				end
				ST_SCAN: begin
					// read for state scan_idx_q goes out, data of the previous one comes back
					if (hit_s1) begin
						acc_q <= acc_q | ram_rdata;
					end
					scan_idx_q <= scan_idx_q + state_idx_t'(1);
					if (scan_idx_q == state_idx_t'(NUM_STATES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cur_q   <= hit_s1 ? (acc_q | ram_rdata) : acc_q;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						active_q    <= MASK_W'(cur_q);
						accepted_q  <= |(cur_q & final_set);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign active_states = active_q;
	assign accepted      = accepted_q;

	`NWA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`NWA_ASSERT_NEXT(a_scan_ends_in_drain, clk, arst_n, scan_last, state_q == ST_DRAIN)
	`NWA_ASSERT_NOW(a_result_from_finish, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_FINISH))
	`NWA_ASSERT_NOW(a_accepted_nonempty, clk, arst_n, out_valid_q && accepted_q, active_q != '0)

endmodule
